// ===== hw/rtl/mvdac_pkg.sv =====
// Shared types, constants and the divider step for the millivolt to DAC code converter.
`default_nettype none

package mvdac_pkg;

    // Code resolution and derived divider widths
    localparam int CODE_BITS = 16;
    localparam int QW        = CODE_BITS + 1;          // quotient bits
    localparam int NW        = CODE_BITS + 17;         // numerator bits
    localparam int XW        = (QW > 16) ? QW : 16;    // code before field truncation
    localparam int NSTG      = QW + 1;                 // load stage plus one stage per bit

    // Job queue depth
    localparam int QD  = 4;
    localparam int QAW = $clog2(QD);

    // Target channel selector codes
    localparam logic [1:0] MODE_A    = 2'd0;
    localparam logic [1:0] MODE_B    = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [1:0] REG_ZERO_A    = 2'd2;
    localparam logic [1:0] REG_ZERO_B    = 2'd3;

    // Reset values of the configuration registers
    localparam logic signed [15:0] RST_RANGE_MIN = -16'sd10000;
    localparam logic signed [15:0] RST_RANGE_MAX = 16'sd10000;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_FULL,
        CLS_DIV
    } t_cls;

    typedef struct packed {
        logic signed [15:0] voltage_mv;
        logic [1:0]         mode;
    } t_in;

    typedef struct packed {
        logic        channel;
        logic [15:0] code;
        logic        last;
    } t_out;

    // One channel conversion handed from front to back
    typedef struct packed {
        logic        channel;
        logic        last;
        t_cls        cls;
        logic [15:0] s;
        logic [15:0] span;
    } t_job;

    // Divider pipeline stage
    typedef struct packed {
        logic          valid;
        logic          channel;
        logic          last;
        t_cls          cls;
        logic [15:0]   rem;
        logic [QW-1:0] num;
        logic [15:0]   span;
        logic [QW-1:0] quo;
    } t_stg;

    // One restoring division step: shift in a numerator bit, subtract if it fits
    function automatic t_stg div_step(input t_stg a);
        logic [16:0] rx;
        logic        ge;
        t_stg        b;
        b     = a;
        rx    = {a.rem, a.num[QW-1]};
        ge    = (rx >= {1'b0, a.span});
        b.rem = ge ? 16'(rx - {1'b0, a.span}) : rx[15:0];
        b.num = {a.num[QW-2:0], 1'b0};
        b.quo = {a.quo[QW-2:0], ge};
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mvdac_front.sv =====
// Front end: configuration registers, input capture, clamp and classification into jobs.
`default_nettype none

module mvdac_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire mvdac_pkg::t_in    i_in_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output mvdac_pkg::t_job        o_job
);

    logic signed [15:0] r_min, r_max, r_zero_a, r_zero_b;
    logic               r_valid;
    logic               r_second;
    mvdac_pkg::t_in     r_item;

    logic               mode_ok;
    logic               finishing;
    logic               load;
    logic               job_channel;
    logic               job_last;
    logic signed [15:0] v_in;
    logic signed [15:0] v_clamp;
    logic signed [15:0] zero_sel;
    logic signed [16:0] diff;
    logic signed [16:0] span;
    logic signed [17:0] s_val;
    logic signed [17:0] span_x;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= mvdac_pkg::RST_RANGE_MIN;
            r_max    <= mvdac_pkg::RST_RANGE_MAX;
            r_zero_a <= '0;
            r_zero_b <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mvdac_pkg::REG_RANGE_MIN: r_min    <= $signed(i_cfg_data);
                mvdac_pkg::REG_RANGE_MAX: r_max    <= $signed(i_cfg_data);
                mvdac_pkg::REG_ZERO_A:    r_zero_a <= $signed(i_cfg_data);
                mvdac_pkg::REG_ZERO_B:    r_zero_b <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Issue one job per cycle unless the queue is full; for both channels, A then B
    always_comb begin
        mode_ok = (r_item.mode == mvdac_pkg::MODE_A) ||
                  (r_item.mode == mvdac_pkg::MODE_B) ||
                  (r_item.mode == mvdac_pkg::MODE_BOTH);
        o_push      = r_valid && mode_ok && !i_q_full;
        job_channel = (r_item.mode == mvdac_pkg::MODE_B) || r_second;
        job_last    = (r_item.mode != mvdac_pkg::MODE_BOTH) || r_second;
        // Unused mode code is dropped without a result
        finishing  = r_valid && (!mode_ok || (o_push && job_last));
        load       = !r_valid || finishing;
        o_in_stall = !load;
    end

    // Clamp, remove range minimum and zero offset, classify
    always_comb begin
        v_in     = $signed(r_item.voltage_mv);
        zero_sel = job_channel ? r_zero_b : r_zero_a;
        if (v_in > r_max) begin
            v_clamp = r_max;
        end else if (v_in < r_min) begin
            v_clamp = r_min;
        end else begin
            v_clamp = v_in;
        end
        diff   = $signed({v_clamp[15], v_clamp}) - $signed({r_min[15], r_min});
        span   = $signed({r_max[15], r_max}) - $signed({r_min[15], r_min});
        s_val  = $signed({diff[16], diff}) - $signed({{2{zero_sel[15]}}, zero_sel});
        span_x = $signed({span[16], span});
        o_job.channel = job_channel;
        o_job.last    = job_last;
        if (s_val <= 18'sd0) begin
            o_job.cls = mvdac_pkg::CLS_ZERO;
        end else if (s_val >= span_x) begin
            o_job.cls = mvdac_pkg::CLS_FULL;
        end else begin
            o_job.cls = mvdac_pkg::CLS_DIV;
        end
        o_job.s    = s_val[15:0];
        o_job.span = span[15:0];
    end

    // Hold the current transaction until its last job is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= i_in_valid;
            r_second <= 1'b0;
        end else if (o_push) begin
            r_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_in_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mvdac_queue.sv =====
// Short job queue between the front end and the divider back end.
`default_nettype none

module mvdac_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mvdac_pkg::t_job i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output mvdac_pkg::t_job      o_job
);

    mvdac_pkg::t_job              r_mem [0:mvdac_pkg::QD-1];
    logic [mvdac_pkg::QAW-1:0]    r_wr;
    logic [mvdac_pkg::QAW-1:0]    r_rd;
    logic [mvdac_pkg::QAW:0]      r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (mvdac_pkg::QAW + 1)'(mvdac_pkg::QD));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mvdac_back.sv =====
// Back end: pipelined restoring divider, saturation and output register.
`default_nettype none

module mvdac_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire mvdac_pkg::t_job i_job,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output mvdac_pkg::t_out      o_out_data
);

    mvdac_pkg::t_stg r_stg [0:mvdac_pkg::NSTG-1];
    logic            r_out_valid;
    mvdac_pkg::t_out r_out;

    logic                        en;
    logic [mvdac_pkg::NW-1:0]    nsum;
    mvdac_pkg::t_stg             n_stg0;
    mvdac_pkg::t_stg             n_stg [1:mvdac_pkg::NSTG-1];
    mvdac_pkg::t_stg             last_stg;
    logic [mvdac_pkg::QW-1:0]    code_q;
    logic [mvdac_pkg::XW-1:0]    code_x;
    mvdac_pkg::t_out             n_out;

    // Whole pipeline moves together whenever the output slot frees up
    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && i_q_valid;

    // Build the rounded numerator and take its top bits as the first remainder
    always_comb begin
        nsum = {1'b0, i_job.s, {mvdac_pkg::CODE_BITS{1'b0}}} +
               mvdac_pkg::NW'(i_job.span[15:1]);
        n_stg0.valid   = i_q_valid;
        n_stg0.channel = i_job.channel;
        n_stg0.last    = i_job.last;
        n_stg0.cls     = i_job.cls;
        n_stg0.rem     = nsum[mvdac_pkg::NW-1:mvdac_pkg::QW];
        n_stg0.num     = nsum[mvdac_pkg::QW-1:0];
        n_stg0.span    = i_job.span;
        n_stg0.quo     = '0;
    end

    // One quotient bit per stage
    always_comb begin
        for (int k = 1; k < mvdac_pkg::NSTG; k++) begin
            n_stg[k] = mvdac_pkg::div_step(r_stg[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mvdac_pkg::NSTG; k++) begin
                r_stg[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_stg[0] <= n_stg0;
            for (int k = 1; k < mvdac_pkg::NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Saturate and select the code for the job class
    always_comb begin
        last_stg = r_stg[mvdac_pkg::NSTG-1];
        code_q   = last_stg.quo[mvdac_pkg::QW-1] ?
                   {1'b0, {mvdac_pkg::CODE_BITS{1'b1}}} : last_stg.quo;
        unique case (last_stg.cls)
            mvdac_pkg::CLS_ZERO: code_x = '0;
            mvdac_pkg::CLS_FULL: code_x = mvdac_pkg::XW'({1'b0, {mvdac_pkg::CODE_BITS{1'b1}}});
            mvdac_pkg::CLS_DIV:  code_x = mvdac_pkg::XW'(code_q);
            default:             code_x = '0;
        endcase
        n_out.channel = last_stg.channel;
        n_out.code    = code_x[15:0];
        n_out.last    = last_stg.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last_stg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/millivolt_to_dac_code_top.sv =====
// Top level of the millivolt to DAC code converter.
// Converts a requested voltage in millivolts to a DAC code for channel A, channel B or
// both (A first, then B; last marks the final code of a request). The front end takes a
// single-channel request every cycle and holds a both-channel request until both its jobs
// are issued; it issues one channel job per cycle into a four-entry queue unless it is
// full. The back end is a restoring divider with one stage per quotient bit (CODE_BITS+1
// stages) plus a load stage and an output register, so it finishes one code per cycle
// unless the output stalls; a request's first code passes the input register, queue,
// load stage, divider stages and output register. Mode 3 is consumed with no result.
// Configuration registers (0 range min, 1 range max, 2 zero offset A, 3 zero offset B)
// may be written only while no request is in flight.
`default_nettype none

module millivolt_to_dac_code_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire mvdac_pkg::t_in  i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output mvdac_pkg::t_out      o_out_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [15:0]     i_cfg_data
);

    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            pop;
    mvdac_pkg::t_job push_job;
    mvdac_pkg::t_job q_job;

    mvdac_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    mvdac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    mvdac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mvdac_chk.sv =====
// Port-level checker for the millivolt to DAC code converter, bound to the top level.
`default_nettype none

module mvdac_chk (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_stall,
    input wire mvdac_pkg::t_in  i_in_data,
    input wire logic            o_out_valid,
    input wire logic            i_out_stall,
    input wire mvdac_pkg::t_out o_out_data,
    input wire logic            i_cfg_valid,
    input wire logic            o_cfg_ready,
    input wire logic [1:0]      i_cfg_index,
    input wire logic [15:0]     i_cfg_data
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Only the channel A code of a both-channel request lacks last
    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_out_data.channel)
        else $error("non-final result not on channel A");

    // A non-final A code is followed by its B code once the A code is taken
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last |=> o_out_valid ##0
        (o_out_data.channel && o_out_data.last))
        else $error("channel B code did not follow channel A code");

endmodule

bind millivolt_to_dac_code_top mvdac_chk u_chk (.*);

`default_nettype wire
